// ===== sv/abcb_pkg.sv =====
`default_nettype none

package abcb_pkg;

	localparam int CH_W       = 8;
	localparam int RGB_W      = 3 * CH_W;
	localparam int PIX_W      = 32;
	localparam int DIM_W      = 13;
	localparam int STRIDE_W   = 14;
	localparam int CFG_W      = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int ADDR_W     = 25;

	localparam int MAX_DIM_DEF    = 4096;
	localparam int MAX_STRIDE_DEF = 8192;

	localparam logic [CH_W-1:0] FULL_ALPHA = 8'hFF;
	localparam logic [CH_W-1:0] ZERO_ALPHA = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PLACE_X       = 3'd0,
		CFG_PLACE_Y       = 3'd1,
		CFG_IMAGE_WIDTH   = 3'd2,
		CFG_IMAGE_HEIGHT  = 3'd3,
		CFG_TARGET_WIDTH  = 3'd4,
		CFG_TARGET_HEIGHT = 3'd5,
		CFG_TARGET_STRIDE = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic             hit;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		logic             last;
	} pos_t;

endpackage

`default_nettype wire

// ===== sv/abcb_if.sv =====
`default_nettype none

interface abcb_src_if;
	logic                       valid;
	logic                       ready;
	logic [abcb_pkg::CH_W-1:0]  src_red;
	logic [abcb_pkg::CH_W-1:0]  src_green;
	logic [abcb_pkg::CH_W-1:0]  src_blue;
	logic [abcb_pkg::CH_W-1:0]  src_alpha;
	logic [abcb_pkg::PIX_W-1:0] dst_pixel;

	modport source (output valid, src_red, src_green, src_blue, src_alpha, dst_pixel,
		input ready);
	modport sink (input valid, src_red, src_green, src_blue, src_alpha, dst_pixel,
		output ready);
endinterface

interface abcb_fb_if;
	logic                        valid;
	logic                        ready;
	logic                        write_enable;
	logic [abcb_pkg::ADDR_W-1:0] target_address;
	logic [abcb_pkg::PIX_W-1:0]  new_pixel;
	logic                        last_pixel;

	modport source (output valid, write_enable, target_address, new_pixel, last_pixel,
		input ready);
	modport sink (input valid, write_enable, target_address, new_pixel, last_pixel,
		output ready);
endinterface

`default_nettype wire

// ===== sv/abcb_pos.sv =====
`default_nettype none

module abcb_pos #(
	parameter int MAX_DIM    = abcb_pkg::MAX_DIM_DEF,
	parameter int MAX_STRIDE = abcb_pkg::MAX_STRIDE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [abcb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [abcb_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             take,
	output abcb_pkg::pos_t                   pos,
	output logic [abcb_pkg::STRIDE_W-1:0]    stride
);

	localparam int DW = abcb_pkg::DIM_W;
	localparam int CW = $clog2(MAX_DIM);
	localparam int LW = (CW + 1 > DW) ? CW + 1 : DW;
	localparam int PW = ((DW > CW + 1) ? DW : CW + 1) + 1;

	logic signed [DW-1:0]               place_x_q;
	logic signed [DW-1:0]               place_y_q;
	logic [DW-1:0]                      image_w_q;
	logic [DW-1:0]                      image_h_q;
	logic [DW-1:0]                      target_w_q;
	logic [DW-1:0]                      target_h_q;
	logic [abcb_pkg::STRIDE_W-1:0]      stride_q;
	logic [CW-1:0]                      col_q;
	logic [CW-1:0]                      row_q;

	logic [DW-1:0]                      dim_sat;
	logic [abcb_pkg::STRIDE_W-1:0]      stride_sat;
	logic                               known_idx;
	logic                               empty;
	logic [LW-1:0]                      col_inc;
	logic [LW-1:0]                      row_inc;
	logic                               col_end;
	logic                               row_end;
	logic signed [PW-1:0]               tx;
	logic signed [PW-1:0]               ty;
	logic                               in_x;
	logic                               in_y;

	assign dim_sat = (int'(cfg_data[DW-1:0]) > MAX_DIM) ? DW'(MAX_DIM) : cfg_data[DW-1:0];
	assign stride_sat = (int'(cfg_data) > MAX_STRIDE) ?
		abcb_pkg::STRIDE_W'(MAX_STRIDE) : cfg_data;
	assign known_idx = (cfg_index <= abcb_pkg::CFG_TARGET_STRIDE);

	assign empty   = (image_w_q == '0) || (image_h_q == '0);
	assign col_inc = LW'(col_q) + LW'(1);
	assign row_inc = LW'(row_q) + LW'(1);
	assign col_end = (col_inc == LW'(image_w_q));
	assign row_end = (row_inc == LW'(image_h_q));

	assign tx = PW'(place_x_q) + PW'(signed'({1'b0, col_q}));
	assign ty = PW'(place_y_q) + PW'(signed'({1'b0, row_q}));
	assign in_x = !tx[PW-1] && (tx[PW-2:0] < (PW-1)'(target_w_q));
	assign in_y = !ty[PW-1] && (ty[PW-2:0] < (PW-1)'(target_h_q));

	assign pos.hit  = !empty && (stride_q != '0) && in_x && in_y;
	assign pos.col  = tx[DW-1:0];
	assign pos.row  = ty[DW-1:0];
	assign pos.last = !empty && col_end && row_end;
	assign stride   = stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_x_q  <= '0;
			place_y_q  <= '0;
			image_w_q  <= '0;
			image_h_q  <= '0;
			target_w_q <= '0;
			target_h_q <= '0;
			stride_q   <= '0;
		end else if (cfg_we) begin
			unique case (abcb_pkg::cfg_idx_t'(cfg_index))
				abcb_pkg::CFG_PLACE_X:       place_x_q  <= signed'(cfg_data[DW-1:0]);
				abcb_pkg::CFG_PLACE_Y:       place_y_q  <= signed'(cfg_data[DW-1:0]);
				abcb_pkg::CFG_IMAGE_WIDTH:   image_w_q  <= dim_sat;
				abcb_pkg::CFG_IMAGE_HEIGHT:  image_h_q  <= dim_sat;
				abcb_pkg::CFG_TARGET_WIDTH:  target_w_q <= dim_sat;
				abcb_pkg::CFG_TARGET_HEIGHT: target_h_q <= dim_sat;
				abcb_pkg::CFG_TARGET_STRIDE: stride_q   <= stride_sat;
				default: ;
			endcase
		end
	end

	// A write to any known register restarts the pass over the image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			if (known_idx) begin
				col_q <= '0;
				row_q <= '0;
			end
		end else if (take) begin
			if (empty) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : CW'(row_inc);
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/abcb_blend.sv =====
`default_nettype none

module abcb_blend (
	input  logic [abcb_pkg::CH_W-1:0]  alpha,
	input  logic [abcb_pkg::RGB_W-1:0] src_rgb,
	input  logic [abcb_pkg::RGB_W-1:0] dst_rgb,
	output logic [abcb_pkg::RGB_W-1:0] mix_rgb
);

	localparam int CH = abcb_pkg::CH_W;

	logic [CH-1:0] inv_alpha;

	assign inv_alpha = abcb_pkg::FULL_ALPHA - alpha;

	for (genvar i = 0; i < 3; i++) begin : g_ch
		logic [2*CH-1:0] s_prod;
		logic [2*CH-1:0] d_prod;
		logic [2*CH:0]   sum;
		logic [2*CH:0]   rnd;

		assign s_prod = src_rgb[i*CH +: CH] * alpha;
		assign d_prod = dst_rgb[i*CH +: CH] * inv_alpha;
		assign sum    = (2*CH+1)'(s_prod) + (2*CH+1)'(d_prod);
		// Exact floor division by 255 for sums up to 255 * 255.
		assign rnd    = sum + (2*CH+1)'(1) + (2*CH+1)'(sum[2*CH:CH]);
		assign mix_rgb[i*CH +: CH] = rnd[2*CH-1:CH];
	end

endmodule

`default_nettype wire

// ===== sv/alpha_blit_clip_blend.sv =====
// Source-over alpha blitter with clipping, one source pixel per item.
// Channel src carries the source pixels in raster order, each with the
// framebuffer word currently stored at its mapped location. Channel fb
// returns one item per source pixel: a write enable, the framebuffer word
// address, the new ARGB word and a flag on the final pixel of the image.
// The configuration port writes the placement, image size, target size and stride;
// any write to a known register restarts the image at its first pixel.
// An item is accepted into the input register, and the clip test, blend
// and address multiply run between it and the result register, so a result
// is presented on fb once the item moves on into the result register, and
// leaves at the next edge at which fb is ready.
// Throughput is one item per cycle while fb is ready, as both registers
// then advance together.
// When fb stalls, the result register holds its item and src stays ready
// until the input register is also occupied.
// Reset clears the configuration, the raster counters and both valid flags,
// so nothing is written until an image size, a target size and a stride are configured.
`default_nettype none

module alpha_blit_clip_blend #(
	parameter int MAX_DIM    = abcb_pkg::MAX_DIM_DEF,
	parameter int MAX_STRIDE = abcb_pkg::MAX_STRIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [abcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [abcb_pkg::CFG_W-1:0]     cfg_data,
	abcb_src_if.sink                       src,
	abcb_fb_if.source                      fb
);

	localparam int CH  = abcb_pkg::CH_W;
	localparam int DW  = abcb_pkg::DIM_W;
	localparam int SW  = abcb_pkg::STRIDE_W;
	localparam int AW  = abcb_pkg::ADDR_W;
	localparam int RGB = abcb_pkg::RGB_W;

	logic                  v1_q;
	logic                  v2_q;
	logic                  adv1;
	logic                  adv2;
	logic                  take;

	abcb_pkg::pos_t        pos;
	logic [SW-1:0]         stride;

	abcb_pkg::pos_t        pos_s1;
	logic [CH-1:0]         alpha_s1;
	logic [RGB-1:0]        src_rgb_s1;
	logic [RGB-1:0]        dst_rgb_s1;

	logic [RGB-1:0]        mix_rgb;
	logic [DW+SW-1:0]      row_base;
	logic [DW+SW-1:0]      addr_full;
	logic                  we;

	logic                  we_s2;
	logic [AW-1:0]         addr_s2;
	logic [RGB-1:0]        rgb_s2;
	logic                  last_s2;

	assign adv2      = !v2_q || fb.ready;
	assign adv1      = !v1_q || adv2;
	assign take      = src.valid && adv1;
	assign src.ready = adv1;

	abcb_pos #(
		.MAX_DIM    (MAX_DIM),
		.MAX_STRIDE (MAX_STRIDE)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.pos       (pos),
		.stride    (stride)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (adv1) begin
				v1_q <= src.valid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pos_s1     <= pos;
			alpha_s1   <= src.src_alpha;
			src_rgb_s1 <= {src.src_red, src.src_green, src.src_blue};
			dst_rgb_s1 <= src.dst_pixel[RGB-1:0];
		end
	end

	abcb_blend u_blend (
		.alpha   (alpha_s1),
		.src_rgb (src_rgb_s1),
		.dst_rgb (dst_rgb_s1),
		.mix_rgb (mix_rgb)
	);

	assign we        = pos_s1.hit && (alpha_s1 != abcb_pkg::ZERO_ALPHA);
	assign row_base  = pos_s1.row * stride;
	assign addr_full = row_base + (DW+SW)'(pos_s1.col);

	always_ff @(posedge clk) begin
		if (adv2 && v1_q) begin
			we_s2   <= we;
			addr_s2 <= we ? addr_full[AW-1:0] : '0;
			rgb_s2  <= we ? mix_rgb : '0;
			last_s2 <= pos_s1.last;
		end
	end

	assign fb.valid          = v2_q;
	assign fb.write_enable   = we_s2;
	assign fb.target_address = addr_s2;
	assign fb.new_pixel      = we_s2 ? {abcb_pkg::FULL_ALPHA, rgb_s2} : '0;
	assign fb.last_pixel     = last_s2;

endmodule

`default_nettype wire

// ===== sv/abcb_chk.sv =====
`default_nettype none

module abcb_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          write_enable,
	input wire logic [abcb_pkg::ADDR_W-1:0]   target_address,
	input wire logic [abcb_pkg::PIX_W-1:0]    new_pixel,
	input wire logic                          last_pixel
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_enable)
			&& $stable(target_address) && $stable(new_pixel) && $stable(last_pixel))
		else $error("Stalled result item changed.");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> target_address == '0 && new_pixel == '0)
		else $error("Result item without a write carries nonzero fields.");

	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> new_pixel[abcb_pkg::PIX_W-1 -: abcb_pkg::CH_W]
			== abcb_pkg::FULL_ALPHA)
		else $error("Written pixel is not opaque.");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled while the result register is empty.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("Accepted item did not reach the result register.");

endmodule

bind alpha_blit_clip_blend abcb_chk u_abcb_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (src.valid),
	.in_ready       (src.ready),
	.out_valid      (fb.valid),
	.out_ready      (fb.ready),
	.write_enable   (fb.write_enable),
	.target_address (fb.target_address),
	.new_pixel      (fb.new_pixel),
	.last_pixel     (fb.last_pixel)
);

`default_nettype wire
